[sv/dmpid_pkg.sv]
// Shared types and constants for the dual-mode PID controller.
package dmpid_pkg;

    // Configuration register map: register i lies at byte address 4*i.
    localparam int CFG_ADDR_W = 5;
    localparam int CFG_IDX_W  = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MODE      = 3'd0,
        REG_KP        = 3'd1,
        REG_KI        = 3'd2,
        REG_KD        = 3'd3,
        REG_MAX_OUT   = 3'd4,
        REG_MAX_INTEG = 3'd5
    } reg_idx_t;

    // Controller modes.
    localparam logic MODE_POSITIONAL  = 1'b0;
    localparam logic MODE_INCREMENTAL = 1'b1;

    // Input operation codes.
    localparam logic OP_STEP  = 1'b0;
    localparam logic OP_CLEAR = 1'b1;

    // Reset value of both clamp magnitudes.
    localparam logic [30:0] CLAMP_RESET = 31'h7fff_ffff;

    // Signed 32-bit saturation limits, in the 33-bit form the clamp takes.
    localparam logic signed [32:0] SAT_HI = 33'sh0_7fff_ffff;
    localparam logic signed [32:0] SAT_LO = -33'sh0_8000_0000;

    // Register values as seen by the datapath.
    typedef struct packed {
        logic        mode;
        logic [31:0] kp;
        logic [31:0] ki;
        logic [31:0] kd;
        logic [30:0] max_out;
        logic [30:0] max_integ;
    } cfg_t;

endpackage

[sv/dual_mode_pid_controller_core.sv]
// Dual-mode PID controller: stream ports, APB registers and result register.
// An accepted input beat passes the input register, then the result register on m_tdata.
// Throughput: one beat per cycle while m_tready does not stall; the combinational state
// update loop through the three gain multipliers and the clamps sets that figure.
// Reset (aresetn low, synchronous) clears both stages, the controller state and
// restores register defaults.
module dual_mode_pid_controller_core #(
    parameter int SAMPLE_WIDTH   = 16,
    parameter int GAIN_FRAC_BITS = 16
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // Input stream.
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // s_tdata: setpoint, feedback (from the lowest bit up), zero padded.
    input  logic [((2*SAMPLE_WIDTH+7)/8)*8-1:0] s_tdata,
    // s_tuser: operation.
    input  logic                              s_tuser,
    // Result stream.
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // m_tdata: drive, p_term, i_term, d_term (from the lowest bit up).
    output logic [127:0]                      m_tdata,
    // Configuration port.
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [dmpid_pkg::CFG_ADDR_W-1:0]  paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready
);
    import dmpid_pkg::*;

    cfg_t                           cfg;
    logic                           in_vld_reg;
    logic                           in_op_reg;
    logic signed [SAMPLE_WIDTH-1:0] in_sp_reg, in_fb_reg;
    logic                           out_vld_reg;
    logic [127:0]                   out_data_reg;
    logic                           fire;
    logic signed [31:0]             drive, p_term, i_term, d_term;

    dmpid_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // The step fires when an input beat is held and the result register is free.
    assign fire     = in_vld_reg && (!out_vld_reg || m_tready);
    assign s_tready = !in_vld_reg || fire;

    // Input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_tready) begin
            in_vld_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_op_reg <= s_tuser;
            in_sp_reg <= s_tdata[SAMPLE_WIDTH-1:0];
            in_fb_reg <= s_tdata[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH];
        end
    end

    dmpid_core #(
        .SAMPLE_WIDTH   (SAMPLE_WIDTH),
        .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
    ) u_core (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg),
        .fire     (fire),
        .op       (in_op_reg),
        .setpoint (in_sp_reg),
        .feedback (in_fb_reg),
        .drive    (drive),
        .p_term   (p_term),
        .i_term   (i_term),
        .d_term   (d_term)
    );

    // Result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (fire) begin
            out_vld_reg <= 1'b1;
        end else if (m_tready) begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            out_data_reg <= {d_term, i_term, p_term, drive};
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_data_reg;

    // A clear step yields an all-zero result beat.
    a_clear_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && (in_op_reg == OP_CLEAR) |=> out_data_reg == '0)
        else $error("clear step did not give a zero result");

    // The drive value stays within the output clamp in force when it was formed.
    a_drive_clamped: assert property (@(posedge aclk) disable iff (!aresetn)
        fire |=> ($signed(out_data_reg[31:0]) <= $signed({1'b0, $past(cfg.max_out)}))
              && ($signed(out_data_reg[31:0]) >= -$signed({1'b0, $past(cfg.max_out)})))
        else $error("drive outside the output clamp");

    // A waiting result is never overwritten by a new step.
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        out_vld_reg && !m_tready |-> !fire)
        else $error("result register overwritten while stalled");

endmodule

[sv/dmpid_cfg.sv]
// APB register file holding the mode, gains and clamp magnitudes.
module dmpid_cfg (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [dmpid_pkg::CFG_ADDR_W-1:0]  paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready,
    output dmpid_pkg::cfg_t                   cfg
);
    import dmpid_pkg::*;

    cfg_t     cfg_reg;
    reg_idx_t idx;
    logic     wr_en;

    assign pready = 1'b1;
    assign idx    = reg_idx_t'(paddr[CFG_ADDR_W-1:2]);
    assign wr_en  = psel && penable && pwrite;
    assign cfg    = cfg_reg;

    // Register writes in the access phase.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.mode      <= MODE_POSITIONAL;
            cfg_reg.kp        <= '0;
            cfg_reg.ki        <= '0;
            cfg_reg.kd        <= '0;
            cfg_reg.max_out   <= CLAMP_RESET;
            cfg_reg.max_integ <= CLAMP_RESET;
        end else if (wr_en) begin
            unique case (idx)
                REG_MODE:      cfg_reg.mode      <= pwdata[0];
                REG_KP:        cfg_reg.kp        <= pwdata;
                REG_KI:        cfg_reg.ki        <= pwdata;
                REG_KD:        cfg_reg.kd        <= pwdata;
                REG_MAX_OUT:   cfg_reg.max_out   <= pwdata[30:0];
                REG_MAX_INTEG: cfg_reg.max_integ <= pwdata[30:0];
                default: ;
            endcase
        end
    end

    // Read-back mux.
    always_comb begin
        unique case (idx)
            REG_MODE:      prdata = {31'd0, cfg_reg.mode};
            REG_KP:        prdata = cfg_reg.kp;
            REG_KI:        prdata = cfg_reg.ki;
            REG_KD:        prdata = cfg_reg.kd;
            REG_MAX_OUT:   prdata = {1'b0, cfg_reg.max_out};
            REG_MAX_INTEG: prdata = {1'b0, cfg_reg.max_integ};
            default:       prdata = '0;
        endcase
    end

endmodule

[sv/dmpid_clamp.sv]
// Clamps a wide signed value into a signed range that fits 32 bits.
module dmpid_clamp #(
    parameter int W = 64
) (
    input  logic signed [W-1:0] value,
    input  logic signed [32:0]  hi,
    input  logic signed [32:0]  lo,
    output logic signed [31:0]  y
);
    logic signed [W-1:0] hi_w;
    logic signed [W-1:0] lo_w;

    assign hi_w = W'(hi);
    assign lo_w = W'(lo);

    // Limits are tested first; a value in range fits 32 bits as it is.
    always_comb begin
        if (value > hi_w) begin
            y = hi[31:0];
        end else if (value < lo_w) begin
            y = lo[31:0];
        end else begin
            y = value[31:0];
        end
    end

endmodule

[sv/dmpid_core.sv]
// PID datapath: error history, integral and output state, one step per beat.
module dmpid_core #(
    parameter int SAMPLE_WIDTH   = 16,
    parameter int GAIN_FRAC_BITS = 16
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  dmpid_pkg::cfg_t                cfg,
    input  logic                           fire,
    input  logic                           op,
    input  logic signed [SAMPLE_WIDTH-1:0] setpoint,
    input  logic signed [SAMPLE_WIDTH-1:0] feedback,
    output logic signed [31:0]             drive,
    output logic signed [31:0]             p_term,
    output logic signed [31:0]             i_term,
    output logic signed [31:0]             d_term
);
    import dmpid_pkg::*;

    localparam int EW   = SAMPLE_WIDTH + 1;   // error
    localparam int OPW  = SAMPLE_WIDTH + 3;   // multiplier operand
    localparam int PW   = 32 + OPW;           // exact product
    localparam int SUMW = PW + 2;             // sum of four terms

    logic signed [EW-1:0]   err_prev_reg, err_prev_next;
    logic signed [EW-1:0]   err_prev2_reg, err_prev2_next;
    logic signed [31:0]     integ_reg, integ_next;
    logic signed [31:0]     out_acc_reg, out_acc_next;

    logic signed [EW-1:0]   err;
    logic signed [OPW-1:0]  d1, d2, e_w;
    logic signed [OPW-1:0]  p_op, d_op;
    logic signed [31:0]     kp_s, ki_s, kd_s;
    logic signed [PW-1:0]   p_prod, i_prod, d_prod;
    logic signed [PW-1:0]   p_sh, i_sh, d_sh;
    logic signed [SUMW-1:0] i_sum, drive_sum;
    logic signed [31:0]     i_clamped, sum_base;
    logic signed [PW-1:0]   i_add;
    logic signed [32:0]     iout_hi, iout_lo, out_hi, out_lo;
    logic signed [31:0]     p_sat, i_sat, d_sat, drive_cl;

    // Current error and its first and second differences.
    assign err = EW'(setpoint) - EW'(feedback);
    assign e_w = OPW'(err);
    assign d1  = OPW'(err) - OPW'(err_prev_reg);
    assign d2  = OPW'(err) - (OPW'(err_prev_reg) <<< 1) + OPW'(err_prev2_reg);

    // Operand selection by mode.
    assign p_op = (cfg.mode == MODE_INCREMENTAL) ? d1 : e_w;
    assign d_op = (cfg.mode == MODE_INCREMENTAL) ? d2 : d1;

    // Three gain multipliers; products are floored by the fraction shift.
    assign kp_s   = $signed(cfg.kp);
    assign ki_s   = $signed(cfg.ki);
    assign kd_s   = $signed(cfg.kd);
    assign p_prod = PW'(kp_s) * PW'(p_op);
    assign i_prod = PW'(ki_s) * PW'(e_w);
    assign d_prod = PW'(kd_s) * PW'(d_op);
    assign p_sh   = p_prod >>> GAIN_FRAC_BITS;
    assign i_sh   = i_prod >>> GAIN_FRAC_BITS;
    assign d_sh   = d_prod >>> GAIN_FRAC_BITS;

    // Clamp limits as 33-bit signed values.
    assign iout_hi = $signed({2'b00, cfg.max_integ});
    assign iout_lo = -iout_hi;
    assign out_hi  = $signed({2'b00, cfg.max_out});
    assign out_lo  = -out_hi;

    // Positional integral: accumulate and clamp to the integral limit.
    assign i_sum = SUMW'(integ_reg) + SUMW'(i_sh);

    dmpid_clamp #(.W(SUMW)) u_iclamp (
        .value (i_sum),
        .hi    (iout_hi),
        .lo    (iout_lo),
        .y     (i_clamped)
    );

    // Output sum: positional adds the clamped integral, incremental the old output.
    assign sum_base  = (cfg.mode == MODE_INCREMENTAL) ? out_acc_reg : i_clamped;
    assign i_add     = (cfg.mode == MODE_INCREMENTAL) ? i_sh : '0;
    assign drive_sum = SUMW'(sum_base) + SUMW'(p_sh) + SUMW'(i_add) + SUMW'(d_sh);

    dmpid_clamp #(.W(SUMW)) u_oclamp (
        .value (drive_sum),
        .hi    (out_hi),
        .lo    (out_lo),
        .y     (drive_cl)
    );

    // Reported terms saturate to 32 bits.
    dmpid_clamp #(.W(PW)) u_psat (.value(p_sh), .hi(SAT_HI), .lo(SAT_LO), .y(p_sat));
    dmpid_clamp #(.W(PW)) u_isat (.value(i_sh), .hi(SAT_HI), .lo(SAT_LO), .y(i_sat));
    dmpid_clamp #(.W(PW)) u_dsat (.value(d_sh), .hi(SAT_HI), .lo(SAT_LO), .y(d_sat));

    // Results and next state; a clear zeroes both.
    always_comb begin
        if (op == OP_CLEAR) begin
            drive          = '0;
            p_term         = '0;
            i_term         = '0;
            d_term         = '0;
            err_prev_next  = '0;
            err_prev2_next = '0;
            integ_next     = '0;
            out_acc_next   = '0;
        end else begin
            drive          = drive_cl;
            p_term         = p_sat;
            i_term         = (cfg.mode == MODE_INCREMENTAL) ? i_sat : i_clamped;
            d_term         = d_sat;
            err_prev_next  = err;
            err_prev2_next = err_prev_reg;
            integ_next     = i_term;
            out_acc_next   = drive_cl;
        end
    end

    // Controller state, updated once per step.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            err_prev_reg  <= '0;
            err_prev2_reg <= '0;
            integ_reg     <= '0;
            out_acc_reg   <= '0;
        end else if (fire) begin
            err_prev_reg  <= err_prev_next;
            err_prev2_reg <= err_prev2_next;
            integ_reg     <= integ_next;
            out_acc_reg   <= out_acc_next;
        end
    end

endmodule

[bench/pid_predictor_pkg.sv]
`timescale 1ns / 100ps
// Scoreboard class that predicts and checks the PID controller's result beats.
package pid_predictor_pkg;
    import dmpid_pkg::*;

    localparam int GAIN_SHIFT = 16;

    // One result beat: [0] drive, [1] p_term, [2] i_term, [3] d_term.
    typedef logic [3:0][31:0] pid_result_t;

    class pid_predictor;
        logic        ctrl_mode;
        longint      gain_p;
        longint      gain_i;
        longint      gain_d;
        longint      out_limit;
        longint      integ_limit;
        longint      last_err;
        longint      older_err;
        longint      integ_sum;
        longint      held_drive;
        pid_result_t expected_steps[$];
        int          mismatches;

        // Register defaults and cleared controller state, as after reset.
        function new();
            ctrl_mode   = MODE_POSITIONAL;
            gain_p      = 0;
            gain_i      = 0;
            gain_d      = 0;
            out_limit   = longint'(CLAMP_RESET);
            integ_limit = longint'(CLAMP_RESET);
            last_err    = 0;
            older_err   = 0;
            integ_sum   = 0;
            held_drive  = 0;
            mismatches  = 0;
        endfunction

        function void set_reg(reg_idx_t idx, logic [31:0] value);
            case (idx)
                REG_MODE:      ctrl_mode = value[0];
                REG_KP:        gain_p = longint'($signed(value));
                REG_KI:        gain_i = longint'($signed(value));
                REG_KD:        gain_d = longint'($signed(value));
                REG_MAX_OUT:   out_limit = longint'(value[30:0]);
                REG_MAX_INTEG: integ_limit = longint'(value[30:0]);
                default: ;
            endcase
        endfunction

        // Q16.16 gain times an integer operand, floored.
        function longint scaled(longint gain, longint operand);
            return (gain * operand) >>> GAIN_SHIFT;
        endfunction

        function longint limit(longint v, longint mag);
            if (v > mag)
                return mag;
            if (v < -mag)
                return -mag;
            return v;
        endfunction

        function longint sat32(longint v);
            if (v > 64'sd2147483647)
                return 64'sd2147483647;
            if (v < -64'sd2147483648)
                return -64'sd2147483648;
            return v;
        endfunction

        function int outstanding();
            return expected_steps.size();
        endfunction

        // Works out the result of one accepted input beat and queues it.
        function void take_sample(logic op, logic [15:0] sp, logic [15:0] fb);
            longint      err;
            longint      p_raw;
            longint      i_raw;
            longint      d_raw;
            longint      drive;
            pid_result_t r;
            if (op == OP_CLEAR) begin
                last_err   = 0;
                older_err  = 0;
                integ_sum  = 0;
                held_drive = 0;
                expected_steps.push_back('0);
                return;
            end
            err = longint'($signed(sp)) - longint'($signed(fb));
            if (ctrl_mode == MODE_POSITIONAL) begin
                p_raw     = scaled(gain_p, err);
                i_raw     = limit(integ_sum + scaled(gain_i, err), integ_limit);
                d_raw     = scaled(gain_d, err - last_err);
                integ_sum = i_raw;
                drive     = limit(p_raw + i_raw + d_raw, out_limit);
            end else begin
                // Incremental form: the terms are increments of the held output.
                p_raw     = scaled(gain_p, err - last_err);
                i_raw     = scaled(gain_i, err);
                d_raw     = scaled(gain_d, err - 2 * last_err + older_err);
                integ_sum = sat32(i_raw);
                drive     = limit(held_drive + p_raw + i_raw + d_raw, out_limit);
            end
            held_drive = drive;
            older_err  = last_err;
            last_err   = err;
            r[0] = 32'(drive);
            r[1] = 32'(sat32(p_raw));
            r[2] = 32'(sat32(i_raw));
            r[3] = 32'(sat32(d_raw));
            expected_steps.push_back(r);
        endfunction

        task report_mismatch(string what);
            mismatches++;
            $display("%0t: result mismatch: %s", $time, what);
        endtask

        // Compares a result beat with the oldest expectation, field by field.
        task check_response(pid_result_t got);
            pid_result_t want;
            string       names[4];
            int          f;
            names = '{"drive", "p_term", "i_term", "d_term"};
            if (expected_steps.size() == 0) begin
                report_mismatch($sformatf("unexpected result beat %h", got));
                return;
            end
            want = expected_steps.pop_front();
            for (f = 0; f < 4; f++) begin
                if (got[f] !== want[f]) begin
                    report_mismatch($sformatf("%s got %h, expected %h",
                                              names[f], got[f], want[f]));
                end
            end
        endtask
    endclass

endpackage

[bench/dual_mode_pid_controller_core_tb.sv]
`timescale 1ns / 100ps
// Testbench for the dual-mode PID controller core: directed and random beats.
module dual_mode_pid_controller_core_tb;
    import dmpid_pkg::*;
    import pid_predictor_pkg::*;

    localparam int STALL_LIMIT  = 2000;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 4;
    localparam int RAND_PHASES  = 10;
    localparam int PHASE_ITEMS  = 103;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    // s_tdata: setpoint, feedback (from the lowest bit up).
    logic [31:0]           s_tdata;
    // s_tuser: operation.
    logic                  s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    // m_tdata: drive, p_term, i_term, d_term (from the lowest bit up).
    logic [127:0]          m_tdata;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [31:0]           pwdata;
    logic [31:0]           prdata;
    logic                  pready;

    pid_predictor step_predictor;
    bit           calm = 0;
    bit           hold_request = 0;

    dual_mode_pid_controller_core #(
        .SAMPLE_WIDTH   (16),
        .GAIN_FRAC_BITS (16)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Either side idles with a chance of 19 in a hundred, except in calm phases.
    function automatic logic idle_now();
        return !calm && ($urandom_range(0, 99) < 19);
    endfunction

    function automatic logic [15:0] rand_sample();
        case ($urandom_range(0, 9))
            0:       return $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
            1, 2:    return 16'($urandom_range(0, 400)) - 16'd200;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [31:0] rand_gain();
        case ($urandom_range(0, 5))
            0:       return $urandom;
            1:       return $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
            2:       return 32'h0;
            // Gains within plus or minus 4.0.
            default: return 32'($urandom_range(0, 32'h0008_0000)) - 32'h0004_0000;
        endcase
    endfunction

    function automatic logic [30:0] rand_limit();
        case ($urandom_range(0, 4))
            0:       return 31'd0;
            1:       return CLAMP_RESET;
            2:       return 31'($urandom);
            default: return 31'($urandom_range(0, 2000000));
        endcase
    endfunction

    function automatic cfg_t make_cfg(logic mode, logic [31:0] kp, logic [31:0] ki,
                                      logic [31:0] kd, logic [30:0] max_out,
                                      logic [30:0] max_integ);
        cfg_t c;
        c.mode      = mode;
        c.kp        = kp;
        c.ki        = ki;
        c.kd        = kd;
        c.max_out   = max_out;
        c.max_integ = max_integ;
        return c;
    endfunction

    // Writes all six registers back to back, in register map order.
    task automatic apply_config(cfg_t c);
        logic [31:0] vals [6];
        int          n;
        vals = '{32'(c.mode), c.kp, c.ki, c.kd, 32'(c.max_out), 32'(c.max_integ)};
        for (n = 0; n < 6; n++) begin
            psel    <= 1'b1;
            penable <= 1'b0;
            pwrite  <= 1'b1;
            paddr   <= {reg_idx_t'(n), 2'b00};
            pwdata  <= vals[n];
            @(posedge aclk);
            penable <= 1'b1;
            do @(negedge aclk); while (!pready);
            @(posedge aclk);
            step_predictor.set_reg(reg_idx_t'(n), vals[n]);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Offers one input beat and waits until it is taken.
    task automatic send_item(logic op, logic [15:0] sp, logic [15:0] fb);
        while (idle_now()) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {fb, sp};
        do @(negedge aclk); while (!s_tready);
        @(posedge aclk);
        step_predictor.take_sample(op, sp, fb);
    endtask

    // Stops sending and waits until every expected result beat has arrived.
    task automatic settle();
        s_tvalid <= 1'b0;
        while (step_predictor.outstanding() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // Result side: random back-pressure, one long hold-off on request, checking.
    initial begin : result_sink
        logic         fire;
        logic [127:0] beat;
        int           hold_left;
        hold_left = 0;
        m_tready  <= 1'b0;
        forever begin
            @(negedge aclk);
            fire = aresetn && m_tvalid && m_tready;
            beat = m_tdata;
            @(posedge aclk);
            if (fire)
                step_predictor.check_response(beat);
            if (hold_request) begin
                hold_request = 1'b0;
                hold_left    = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= !idle_now();
            end
        end
    end

    // Watchdog: ends the run when no beat or register write moves for too long.
    initial begin : watchdog
        int quiet;
        quiet = 0;
        forever begin
            @(negedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel)
                quiet = 0;
            else
                quiet++;
            if (quiet >= STALL_LIMIT) begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    // Stimulus.
    initial begin : stimulus
        cfg_t c;
        int   ph;
        int   k;
        logic op;
        step_predictor = new();
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= OP_STEP;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // Register defaults: zero gains give zero results even at extreme errors.
        send_item(OP_STEP, 16'h7fff, 16'h8000);
        send_item(OP_STEP, 16'h8000, 16'h7fff);
        settle();

        // Positional mode with moderate gains and clamps that bite.
        apply_config(make_cfg(MODE_POSITIONAL, 32'h0001_0000, 32'h0000_8000,
                              32'h0002_0000, 31'd100000, 31'd50000));
        send_item(OP_STEP, 16'd100, 16'd0);
        send_item(OP_STEP, 16'h7fff, 16'h8000);
        send_item(OP_STEP, 16'h7fff, 16'h8000);
        send_item(OP_STEP, 16'h8000, 16'h7fff);
        send_item(OP_CLEAR, 16'h7fff, 16'h8000);
        send_item(OP_STEP, 16'd0, 16'd0);
        settle();

        // Extreme gains: the reported terms saturate.
        apply_config(make_cfg(MODE_POSITIONAL, 32'h7fff_ffff, 32'h8000_0000,
                              32'h8000_0000, CLAMP_RESET, CLAMP_RESET));
        send_item(OP_STEP, 16'h7fff, 16'h8000);
        send_item(OP_STEP, 16'h8000, 16'h7fff);
        send_item(OP_STEP, 16'h8000, 16'h7fff);
        settle();

        // Switch to incremental mode with the history kept.
        apply_config(make_cfg(MODE_INCREMENTAL, 32'h7fff_ffff, 32'h8000_0000,
                              32'h8000_0000, CLAMP_RESET, CLAMP_RESET));
        send_item(OP_STEP, 16'h7fff, 16'h8000);
        send_item(OP_STEP, 16'h8000, 16'h7fff);
        send_item(OP_STEP, 16'h7fff, 16'h8000);
        send_item(OP_CLEAR, 16'h8000, 16'h7fff);
        settle();

        // Zero clamps force the output, and in positional mode the integral, to zero.
        apply_config(make_cfg(MODE_POSITIONAL, 32'h0001_0000, 32'h0001_0000,
                              32'h0001_0000, 31'd0, 31'd0));
        send_item(OP_STEP, 16'd1000, 16'hfc18);
        send_item(OP_STEP, 16'hfffb, 16'd5);
        settle();
        apply_config(make_cfg(MODE_INCREMENTAL, 32'h0001_0000, 32'h0001_0000,
                              32'h0001_0000, 31'd0, 31'd0));
        send_item(OP_STEP, 16'd123, 16'd0);
        settle();

        // Back to positional: the integral carries over from incremental mode.
        apply_config(make_cfg(MODE_POSITIONAL, 32'h0000_4000, 32'hffff_8000,
                              32'h0003_0000, CLAMP_RESET, 31'd5));
        send_item(OP_STEP, 16'hb1e0, 16'h4e20);
        send_item(OP_STEP, 16'h4e20, 16'hb1e0);
        settle();

        // Random phases, each with a fresh random register setting.
        for (ph = 0; ph < RAND_PHASES; ph++) begin
            c = make_cfg($urandom_range(0, 1) ? MODE_INCREMENTAL : MODE_POSITIONAL,
                         rand_gain(), rand_gain(), rand_gain(),
                         rand_limit(), rand_limit());
            apply_config(c);
            calm = (ph == 3);
            // Long hold-off on the result side while the sender keeps offering.
            if (ph == 6)
                hold_request = 1'b1;
            for (k = 0; k < PHASE_ITEMS; k++) begin
                op = ($urandom_range(0, 99) < 3) ? OP_CLEAR : OP_STEP;
                send_item(op, rand_sample(), rand_sample());
            end
            settle();
            calm = 1'b0;
        end

        if (step_predictor.mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
